[hdl/spd_pkg.sv]
// ----------------------------------------------------------------------------
// spd_pkg: shared types and constants of the segment pair distance unit
// Word layouts of both channels, fixed field widths and the per-pass record
// that the front end hands to the root and divide pipelines.
// ----------------------------------------------------------------------------
package spd_pkg;

	localparam int COORD_W   = 18;            // unsigned Q10.8 coordinate
	localparam int DIFF_W    = COORD_W + 1;   // signed coordinate difference
	localparam int PROD_W    = 2 * DIFF_W;    // product of two differences
	localparam int SUM_W     = PROD_W + 1;    // sum of two products
	localparam int TOL_W     = 16;
	localparam int DIST_W    = 19;            // unsigned Q11.8 distance
	localparam int AC_W      = PROD_W;        // magnitude of a cross product
	localparam int NUM_SHIFT = 8;             // cross magnitude scale before divide
	localparam int LEN_SHIFT = 16;            // squared length scale before root
	localparam int RAD_W     = PROD_W + LEN_SHIFT;
	localparam int ROOT_W    = RAD_W / 2;

	localparam logic [DIST_W-1:0] DIST_MAX = {DIST_W{1'b1}};
	localparam logic [TOL_W-1:0]  TOL_RESET = TOL_W'(1);

	typedef struct packed {
		logic [COORD_W-1:0] x;
		logic [COORD_W-1:0] y;
	} pt_t;

	typedef struct packed {
		logic [COORD_W-1:0] a_start_x;
		logic [COORD_W-1:0] a_start_y;
		logic [COORD_W-1:0] a_end_x;
		logic [COORD_W-1:0] a_end_y;
		logic [COORD_W-1:0] b_start_x;
		logic [COORD_W-1:0] b_start_y;
		logic [COORD_W-1:0] b_end_x;
		logic [COORD_W-1:0] b_end_y;
	} pair_t;

	typedef struct packed {
		logic [DIST_W-1:0] seg_distance;
		logic              intersects;
		logic              degenerate;
	} dist_t;

	// One distance pass after the front end: endpoint mode takes the root of
	// rad as the distance, otherwise rad is the scaled squared length and ac
	// the cross magnitude to divide by its root.
	typedef struct packed {
		logic             deg;
		logic             ep;
		logic [RAD_W-1:0] rad;
		logic [AC_W-1:0]  ac;
	} pass_t;

endpackage

[hdl/spd_front.sv]
// ----------------------------------------------------------------------------
// spd_front: products, orientation test and pass setup
// Four pipeline stages: differences, products, sums, then the touch decision
// and the choice between endpoint and perpendicular distance for each pass.
// ----------------------------------------------------------------------------
module spd_front (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             en,
	input  logic                             in_vld,
	input  spd_pkg::pair_t                   pair,
	input  logic [spd_pkg::TOL_W-1:0]        tol,
	output logic                             out_vld,
	output logic                             intersects,
	output spd_pkg::pass_t [1:0]             pass_res
);

	localparam logic [1:0] ORI_COLIN = 2'd0;
	localparam logic [1:0] ORI_POS   = 2'd1;
	localparam logic [1:0] ORI_NEG   = 2'd2;

	// Difference slots of one pass.
	localparam int D_DX = 0, D_DY = 1, D_UXS = 2, D_UYS = 3;
	localparam int D_UXE = 4, D_UYE = 5, D_WX = 6, D_WY = 7;

	function automatic logic signed [spd_pkg::DIFF_W-1:0] sub(
		input logic [spd_pkg::COORD_W-1:0] a,
		input logic [spd_pkg::COORD_W-1:0] b
	);
		return $signed({1'b0, a}) - $signed({1'b0, b});
	endfunction

	// True when t lies in the bounding box of p and r.
	function automatic logic on_seg(input spd_pkg::pt_t p, input spd_pkg::pt_t r,
		input spd_pkg::pt_t t);
		logic [spd_pkg::COORD_W-1:0] xmax, xmin, ymax, ymin;
		xmax = (p.x > r.x) ? p.x : r.x;
		xmin = (p.x < r.x) ? p.x : r.x;
		ymax = (p.y > r.y) ? p.y : r.y;
		ymin = (p.y < r.y) ? p.y : r.y;
		return (t.x <= xmax) && (t.x >= xmin) && (t.y <= ymax) && (t.y >= ymin);
	endfunction

	spd_pkg::pt_t as_p, ae_p, bs_p, be_p;
	spd_pkg::pt_t opp [4];
	spd_pkg::pt_t opq [4];
	spd_pkg::pt_t opr [4];
	spd_pkg::pt_t rs [2];
	spd_pkg::pt_t re [2];
	spd_pkg::pt_t qs [2];
	spd_pkg::pt_t qe [2];

	logic                                v_s1, v_s2, v_s3, v_s4;
	logic signed [spd_pkg::DIFF_W-1:0]   od_s1 [4][4];
	logic [3:0]                          os_s1, os_s2, os_s3;
	logic signed [spd_pkg::DIFF_W-1:0]   pd_s1 [2][8];
	logic signed [spd_pkg::PROD_W-1:0]   op_s2 [4][2];
	logic signed [spd_pkg::PROD_W-1:0]   pp_s2 [2][14];
	logic signed [spd_pkg::SUM_W-1:0]    ov_s3 [4];
	logic signed [spd_pkg::SUM_W-1:0]    ps_s3 [2][7];
	logic                                intersects_s4;
	spd_pkg::pass_t [1:0]                pass_s4;

	logic signed [spd_pkg::SUM_W-1:0]    tol_s;
	logic [1:0]                          ori [4];
	logic                                touch;
	spd_pkg::pass_t [1:0]                pass_c;

	// Orientation triples and the two passes: B is the reference first.
	always_comb begin
		as_p = '{x: pair.a_start_x, y: pair.a_start_y};
		ae_p = '{x: pair.a_end_x,   y: pair.a_end_y};
		bs_p = '{x: pair.b_start_x, y: pair.b_start_y};
		be_p = '{x: pair.b_end_x,   y: pair.b_end_y};
		opp[0] = as_p; opq[0] = ae_p; opr[0] = bs_p;
		opp[1] = as_p; opq[1] = ae_p; opr[1] = be_p;
		opp[2] = bs_p; opq[2] = be_p; opr[2] = as_p;
		opp[3] = bs_p; opq[3] = be_p; opr[3] = ae_p;
		rs[0] = bs_p; re[0] = be_p; qs[0] = as_p; qe[0] = ae_p;
		rs[1] = as_p; re[1] = ae_p; qs[1] = bs_p; qe[1] = be_p;
		for (int p = 0; p < 2; p++) begin
			if (rs[p].x > re[p].x) begin
				rs[p] = re[p];
				re[p] = (p == 0) ? bs_p : as_p;
			end
			if (qs[p].x > qe[p].x) begin
				qs[p] = qe[p];
				qe[p] = (p == 0) ? as_p : bs_p;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_vld;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	// Stage 1: differences and bounding box tests.
	always_ff @(posedge clk) begin
		if (en) begin
			for (int o = 0; o < 4; o++) begin
				od_s1[o][0] <= sub(opq[o].y, opp[o].y);
				od_s1[o][1] <= sub(opr[o].x, opq[o].x);
				od_s1[o][2] <= sub(opq[o].x, opp[o].x);
				od_s1[o][3] <= sub(opr[o].y, opq[o].y);
				os_s1[o]    <= on_seg(opp[o], opq[o], opr[o]);
			end
			for (int p = 0; p < 2; p++) begin
				pd_s1[p][D_DX]  <= sub(re[p].x, rs[p].x);
				pd_s1[p][D_DY]  <= sub(re[p].y, rs[p].y);
				pd_s1[p][D_UXS] <= sub(qs[p].x, rs[p].x);
				pd_s1[p][D_UYS] <= sub(qs[p].y, rs[p].y);
				pd_s1[p][D_UXE] <= sub(qe[p].x, rs[p].x);
				pd_s1[p][D_UYE] <= sub(qe[p].y, rs[p].y);
				pd_s1[p][D_WX]  <= sub(qs[p].x, re[p].x);
				pd_s1[p][D_WY]  <= sub(qs[p].y, re[p].y);
			end
		end
	end

	// Stage 2: one product per multiplier.
	always_ff @(posedge clk) begin
		if (en) begin
			os_s2 <= os_s1;
			for (int o = 0; o < 4; o++) begin
				op_s2[o][0] <= od_s1[o][0] * od_s1[o][1];
				op_s2[o][1] <= od_s1[o][2] * od_s1[o][3];
			end
			for (int p = 0; p < 2; p++) begin
				pp_s2[p][0]  <= pd_s1[p][D_DX]  * pd_s1[p][D_DX];
				pp_s2[p][1]  <= pd_s1[p][D_DY]  * pd_s1[p][D_DY];
				pp_s2[p][2]  <= pd_s1[p][D_UXS] * pd_s1[p][D_DX];
				pp_s2[p][3]  <= pd_s1[p][D_UYS] * pd_s1[p][D_DY];
				pp_s2[p][4]  <= pd_s1[p][D_UXE] * pd_s1[p][D_DX];
				pp_s2[p][5]  <= pd_s1[p][D_UYE] * pd_s1[p][D_DY];
				pp_s2[p][6]  <= pd_s1[p][D_UYE] * pd_s1[p][D_DX];
				pp_s2[p][7]  <= pd_s1[p][D_UXE] * pd_s1[p][D_DY];
				pp_s2[p][8]  <= pd_s1[p][D_UYS] * pd_s1[p][D_DX];
				pp_s2[p][9]  <= pd_s1[p][D_UXS] * pd_s1[p][D_DY];
				pp_s2[p][10] <= pd_s1[p][D_UXE] * pd_s1[p][D_UXE];
				pp_s2[p][11] <= pd_s1[p][D_UYE] * pd_s1[p][D_UYE];
				pp_s2[p][12] <= pd_s1[p][D_WX]  * pd_s1[p][D_WX];
				pp_s2[p][13] <= pd_s1[p][D_WY]  * pd_s1[p][D_WY];
			end
		end
	end

	// Stage 3: orientation values, squared length, dot and cross products.
	always_ff @(posedge clk) begin
		if (en) begin
			os_s3 <= os_s2;
			for (int o = 0; o < 4; o++) begin
				ov_s3[o] <= spd_pkg::SUM_W'(op_s2[o][0]) - spd_pkg::SUM_W'(op_s2[o][1]);
			end
			for (int p = 0; p < 2; p++) begin
				for (int k = 0; k < 7; k++) begin
					if (k == 3 || k == 4) begin
						ps_s3[p][k] <= spd_pkg::SUM_W'(pp_s2[p][2*k])
							- spd_pkg::SUM_W'(pp_s2[p][2*k+1]);
					end else begin
						ps_s3[p][k] <= spd_pkg::SUM_W'(pp_s2[p][2*k])
							+ spd_pkg::SUM_W'(pp_s2[p][2*k+1]);
					end
				end
			end
		end
	end

	// Stage 4 logic: slots are 0 squared length, 1 and 2 start and end dots,
	// 3 and 4 end and start crosses, 5 and 6 endpoint squared distances.
	always_comb begin
		logic signed [spd_pkg::SUM_W-1:0] c;
		logic signed [spd_pkg::SUM_W-1:0] ca;
		tol_s = $signed({{(spd_pkg::SUM_W - spd_pkg::TOL_W){1'b0}}, tol});
		for (int o = 0; o < 4; o++) begin
			if ((ov_s3[o] <= tol_s) && (ov_s3[o] >= -tol_s)) begin
				ori[o] = ORI_COLIN;
			end else if (ov_s3[o] > 0) begin
				ori[o] = ORI_POS;
			end else begin
				ori[o] = ORI_NEG;
			end
		end
		touch = ((ori[0] != ori[1]) && (ori[2] != ori[3]))
			|| ((ori[0] == ORI_COLIN) && os_s3[0])
			|| ((ori[1] == ORI_COLIN) && os_s3[1])
			|| ((ori[2] == ORI_COLIN) && os_s3[2])
			|| ((ori[3] == ORI_COLIN) && os_s3[3]);
		for (int p = 0; p < 2; p++) begin
			c  = ps_s3[p][1][spd_pkg::SUM_W-1] ? ps_s3[p][3] : ps_s3[p][4];
			ca = c[spd_pkg::SUM_W-1] ? -c : c;
			pass_c[p].deg = (ps_s3[p][0] == '0);
			pass_c[p].ac  = ca[spd_pkg::AC_W-1:0];
			if (ps_s3[p][2][spd_pkg::SUM_W-1]) begin
				pass_c[p].ep  = 1'b1;
				pass_c[p].rad = spd_pkg::RAD_W'(ps_s3[p][5][spd_pkg::PROD_W-1:0]);
			end else if (ps_s3[p][1] > ps_s3[p][0]) begin
				pass_c[p].ep  = 1'b1;
				pass_c[p].rad = spd_pkg::RAD_W'(ps_s3[p][6][spd_pkg::PROD_W-1:0]);
			end else begin
				pass_c[p].ep  = 1'b0;
				pass_c[p].rad = spd_pkg::RAD_W'(ps_s3[p][0][spd_pkg::PROD_W-1:0])
					<< spd_pkg::LEN_SHIFT;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			intersects_s4 <= touch;
			pass_s4       <= pass_c;
		end
	end

	assign out_vld    = v_s4;
	assign intersects = intersects_s4;
	assign pass_res   = pass_s4;

endmodule

[hdl/spd_isqrt.sv]
// ----------------------------------------------------------------------------
// spd_isqrt: pipelined integer square root
// One root bit per stage by the digit-by-digit method; the floor of the root
// leaves after IN_W/2 stages together with its tag.
// ----------------------------------------------------------------------------
module spd_isqrt #(
	parameter int IN_W  = 54,
	parameter int TAG_W = 1
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 en,
	input  logic                 in_vld,
	input  logic [IN_W-1:0]      rad,
	input  logic [TAG_W-1:0]     in_tag,
	output logic                 out_vld,
	output logic [IN_W/2-1:0]    root,
	output logic [TAG_W-1:0]     out_tag
);

	localparam int RT_W  = IN_W / 2;
	localparam int REM_W = RT_W + 2;

	logic [RT_W:1]       vld_s;
	logic [IN_W-1:0]     rad_s [1:RT_W-1];
	logic [REM_W-1:0]    rem_s [1:RT_W-1];
	logic [RT_W-1:0]     rt_s  [1:RT_W];
	logic [TAG_W-1:0]    tag_s [1:RT_W];

	for (genvar k = 0; k < RT_W; k++) begin : g_stage
		logic              cur_vld;
		logic [IN_W-1:0]   cur_rad;
		logic [REM_W-1:0]  cur_rem;
		logic [RT_W-1:0]   cur_rt;
		logic [TAG_W-1:0]  cur_tag;
		logic [REM_W-1:0]  rem_sh;
		logic [REM_W-1:0]  trial;
		logic              ge;

		if (k == 0) begin : g_first
			assign cur_vld = in_vld;
			assign cur_rad = rad;
			assign cur_rem = '0;
			assign cur_rt  = '0;
			assign cur_tag = in_tag;
		end else begin : g_next
			assign cur_vld = vld_s[k];
			assign cur_rad = rad_s[k];
			assign cur_rem = rem_s[k];
			assign cur_rt  = rt_s[k];
			assign cur_tag = tag_s[k];
		end

		assign rem_sh = {cur_rem[REM_W-3:0], cur_rad[IN_W-1 -: 2]};
		assign trial  = {cur_rt, 2'b01};
		assign ge     = (rem_sh >= trial);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k+1] <= 1'b0;
			end else if (en) begin
				vld_s[k+1] <= cur_vld;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rt_s[k+1]  <= {cur_rt[RT_W-2:0], ge};
				tag_s[k+1] <= cur_tag;
			end
		end

		if (k < RT_W - 1) begin : g_carry
			always_ff @(posedge clk) begin
				if (en) begin
					rad_s[k+1] <= cur_rad << 2;
					rem_s[k+1] <= ge ? (rem_sh - trial) : rem_sh;
				end
			end
		end
	end

	assign out_vld = vld_s[RT_W];
	assign root    = rt_s[RT_W];
	assign out_tag = tag_s[RT_W];

endmodule

[hdl/spd_div.sv]
// ----------------------------------------------------------------------------
// spd_div: pipelined restoring divider with saturation
// An overflow check stage, then one quotient bit per stage. A quotient that
// does not fit in Q_W bits comes out as all ones.
// ----------------------------------------------------------------------------
module spd_div #(
	parameter int DEN_W = 27,
	parameter int Q_W   = 19,
	parameter int TAG_W = 1
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    en,
	input  logic                    in_vld,
	input  logic [DEN_W+Q_W-1:0]    num,
	input  logic [DEN_W-1:0]        den,
	input  logic [TAG_W-1:0]        in_tag,
	output logic                    out_vld,
	output logic [Q_W-1:0]          quo,
	output logic [TAG_W-1:0]        out_tag
);

	localparam int NUM_W = DEN_W + Q_W;

	logic [Q_W:0]        vld_s;
	logic [NUM_W-1:0]    rem_s [0:Q_W-1];
	logic [DEN_W-1:0]    den_s [0:Q_W-1];
	logic [Q_W-1:0]      q_s   [0:Q_W];
	logic                ovf_s [0:Q_W];
	logic [TAG_W-1:0]    tag_s [0:Q_W];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (en) begin
			vld_s <= {vld_s[Q_W-1:0], in_vld};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ovf_s[0] <= (num >= {den, {Q_W{1'b0}}});
			rem_s[0] <= num;
			den_s[0] <= den;
			q_s[0]   <= '0;
			tag_s[0] <= in_tag;
		end
	end

	for (genvar k = 0; k < Q_W; k++) begin : g_stage
		logic [NUM_W-1:0] trial;
		logic             ge;

		assign trial = NUM_W'(den_s[k]) << (Q_W - 1 - k);
		assign ge    = (rem_s[k] >= trial);

		always_ff @(posedge clk) begin
			if (en) begin
				q_s[k+1]   <= {q_s[k][Q_W-2:0], ge};
				ovf_s[k+1] <= ovf_s[k];
				tag_s[k+1] <= tag_s[k];
			end
		end

		if (k < Q_W - 1) begin : g_carry
			always_ff @(posedge clk) begin
				if (en) begin
					rem_s[k+1] <= ge ? (rem_s[k] - trial) : rem_s[k];
					den_s[k+1] <= den_s[k];
				end
			end
		end
	end

	assign out_vld = vld_s[Q_W];
	assign quo     = ovf_s[Q_W] ? {Q_W{1'b1}} : q_s[Q_W];
	assign out_tag = tag_s[Q_W];

endmodule

[hdl/segment_pair_distance_unit.sv]
// ----------------------------------------------------------------------------
// segment_pair_distance_unit: approximate distance between two 2D segments
//
// The unit takes one pair of segments per word and returns one result word
// per pair, in order. A fully pipelined datapath accepts a new pair in every
// cycle while the output side takes results; from acceptance to its result,
// each pair passes four front end stages (differences, products,
// sums, touch test and pass setup), 27 square root stages, 20 divider stages
// and the output register. The whole pipeline advances together, so a stall
// on the output holds every stage and the input is not taken until the
// output register frees up. A pair that touches or crosses gives distance
// zero with intersects set. Otherwise both passes run, each against one
// segment as reference, and the smaller distance is returned; a zero-length
// reference sets degenerate and drops that pass, and with no candidate the
// distance saturates at its maximum. The colinear tolerance register may be
// written only while no pair is in flight.
// ----------------------------------------------------------------------------
module segment_pair_distance_unit (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  logic [spd_pkg::TOL_W-1:0]   cfg_wdata,
	input  logic                        pair_valid,
	output logic                        pair_ready,
	input  spd_pkg::pair_t              pair,
	output logic                        dist_valid,
	input  logic                        dist_ready,
	output spd_pkg::dist_t              result
);

	localparam int TAG0_W = 3 + spd_pkg::AC_W;      // intersects, deg, ep, ac
	localparam int TAG1_W = 2 + spd_pkg::AC_W;      // deg, ep, ac
	localparam int DTAG0_W = 3 + spd_pkg::ROOT_W;   // intersects, deg, ep, root
	localparam int DTAG1_W = 2 + spd_pkg::ROOT_W;   // deg, ep, root
	localparam int NUM_W = spd_pkg::ROOT_W + spd_pkg::DIST_W;

	// Results are no longer than the saturation limit once they leave a pass.
	function automatic logic [spd_pkg::DIST_W-1:0] cand(
		input logic                         deg,
		input logic                         ep,
		input logic [spd_pkg::ROOT_W-1:0]   root,
		input logic [spd_pkg::DIST_W-1:0]   quo
	);
		if (deg) begin
			return spd_pkg::DIST_MAX;
		end else if (ep) begin
			return root[spd_pkg::DIST_W-1:0];
		end
		return quo;
	endfunction

	logic [spd_pkg::TOL_W-1:0]     tol_q;
	logic                          adv;

	logic                          fe_vld;
	logic                          fe_int;
	spd_pkg::pass_t [1:0]          fe_pass;

	logic                          sq_vld0, sq_vld1;
	logic [spd_pkg::ROOT_W-1:0]    sq_root0, sq_root1;
	logic [TAG0_W-1:0]             sq_tag0;
	logic [TAG1_W-1:0]             sq_tag1;

	logic                          dv_vld0, dv_vld1;
	logic [spd_pkg::DIST_W-1:0]    dv_quo0, dv_quo1;
	logic [DTAG0_W-1:0]            dv_tag0;
	logic [DTAG1_W-1:0]            dv_tag1;

	logic [spd_pkg::DIST_W-1:0]    c0, c1;
	spd_pkg::dist_t                res_c;
	spd_pkg::dist_t                res_q;
	logic                          vld_q;

	// The whole pipeline moves when the output register is empty or taken.
	assign adv        = !vld_q || dist_ready;
	assign pair_ready = adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tol_q <= spd_pkg::TOL_RESET;
		end else if (cfg_we) begin
			tol_q <= cfg_wdata;
		end
	end

	spd_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.en         (adv),
		.in_vld     (pair_valid),
		.pair       (pair),
		.tol        (tol_q),
		.out_vld    (fe_vld),
		.intersects (fe_int),
		.pass_res   (fe_pass)
	);

	// Pass 0 has B as reference and also carries the touch flag.
	spd_isqrt #(
		.IN_W  (spd_pkg::RAD_W),
		.TAG_W (TAG0_W)
	) u_sqrt0 (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (adv),
		.in_vld  (fe_vld),
		.rad     (fe_pass[0].rad),
		.in_tag  ({fe_int, fe_pass[0].deg, fe_pass[0].ep, fe_pass[0].ac}),
		.out_vld (sq_vld0),
		.root    (sq_root0),
		.out_tag (sq_tag0)
	);

	spd_isqrt #(
		.IN_W  (spd_pkg::RAD_W),
		.TAG_W (TAG1_W)
	) u_sqrt1 (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (adv),
		.in_vld  (fe_vld),
		.rad     (fe_pass[1].rad),
		.in_tag  ({fe_pass[1].deg, fe_pass[1].ep, fe_pass[1].ac}),
		.out_vld (sq_vld1),
		.root    (sq_root1),
		.out_tag (sq_tag1)
	);

	// The perpendicular distance is (|cross| << 8) / root(D << 16).
	spd_div #(
		.DEN_W (spd_pkg::ROOT_W),
		.Q_W   (spd_pkg::DIST_W),
		.TAG_W (DTAG0_W)
	) u_div0 (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (adv),
		.in_vld  (sq_vld0 && sq_vld1),
		.num     (NUM_W'({sq_tag0[spd_pkg::AC_W-1:0], {spd_pkg::NUM_SHIFT{1'b0}}})),
		.den     (sq_root0),
		.in_tag  ({sq_tag0[TAG0_W-1 -: 3], sq_root0}),
		.out_vld (dv_vld0),
		.quo     (dv_quo0),
		.out_tag (dv_tag0)
	);

	spd_div #(
		.DEN_W (spd_pkg::ROOT_W),
		.Q_W   (spd_pkg::DIST_W),
		.TAG_W (DTAG1_W)
	) u_div1 (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (adv),
		.in_vld  (sq_vld1),
		.num     (NUM_W'({sq_tag1[spd_pkg::AC_W-1:0], {spd_pkg::NUM_SHIFT{1'b0}}})),
		.den     (sq_root1),
		.in_tag  ({sq_tag1[TAG1_W-1 -: 2], sq_root1}),
		.out_vld (dv_vld1),
		.quo     (dv_quo1),
		.out_tag (dv_tag1)
	);

	// Pick each pass's candidate, keep the smaller one, and for a touching
	// pair return distance zero with only intersects set.
	always_comb begin
		c0 = cand(dv_tag0[DTAG0_W-2], dv_tag0[DTAG0_W-3],
			dv_tag0[spd_pkg::ROOT_W-1:0], dv_quo0);
		c1 = cand(dv_tag1[DTAG1_W-1], dv_tag1[DTAG1_W-2],
			dv_tag1[spd_pkg::ROOT_W-1:0], dv_quo1);
		if (dv_tag0[DTAG0_W-1]) begin
			res_c.seg_distance = '0;
			res_c.intersects   = 1'b1;
			res_c.degenerate   = 1'b0;
		end else begin
			res_c.seg_distance = (c1 < c0) ? c1 : c0;
			res_c.intersects   = 1'b0;
			res_c.degenerate   = dv_tag0[DTAG0_W-2] || dv_tag1[DTAG1_W-1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (adv) begin
			vld_q <= dv_vld0 && dv_vld1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			res_q <= res_c;
		end
	end

	assign dist_valid = vld_q;
	assign result     = res_q;

endmodule

[test/tb_segment_pair_distance_unit.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_segment_pair_distance_unit: self-checking bench for the distance unit
// Streams directed and random segment pairs through the unit under several
// idle and stall mixes and tolerance settings. Each result word is compared
// with a behavioral prediction of the touch test and the two distance passes.
// ----------------------------------------------------------------------------
module tb_segment_pair_distance_unit;

	localparam int LATENCY = 52;

	// Scoreboard: predicts the result word of each accepted pair and checks
	// the words that come out of the unit in order.
	class dist_scoreboard;
		spd_pkg::dist_t                 pending[$];
		logic [spd_pkg::TOL_W-1:0]      tolerance;
		int                             errors;

		function new();
			tolerance = spd_pkg::TOL_RESET;
			errors = 0;
		endfunction

		function longint unsigned root_floor(longint unsigned v);
			longint unsigned r;
			longint unsigned b;
			r = 0;
			b = 64'd1 << 62;
			while (b > v) b = b >> 2;
			while (b != 0) begin
				if (v >= r + b) begin
					v = v - (r + b);
					r = (r >> 1) + b;
				end else begin
					r = r >> 1;
				end
				b = b >> 2;
			end
			return r;
		endfunction

		function int turn(longint px, longint py, longint qx, longint qy, longint rx, longint ry);
			longint v;
			longint t;
			v = (qy - py) * (rx - qx) - (qx - px) * (ry - qy);
			t = longint'(tolerance);
			if (v <= t && v >= -t) return 0;
			return (v > 0) ? 1 : 2;
		endfunction

		function bit within_box(longint px, longint py, longint qx, longint qy, longint rx,
			longint ry);
			return qx <= ((px > rx) ? px : rx) && qx >= ((px < rx) ? px : rx) &&
				qy <= ((py > ry) ? py : ry) && qy >= ((py < ry) ? py : ry);
		endfunction

		// One pass with (sx,sy)-(ex,ey) as reference; returns 0 for a zero
		// length reference.
		function bit run_pass(longint sx, longint sy, longint ex, longint ey, longint ax,
			longint ay, longint bx, longint by, output longint unsigned pass_dist);
			longint t;
			longint dx, dy, dsq, ts, te, c;
			longint unsigned ac, len;
			pass_dist = 0;
			if (sx > ex) begin
				t = sx; sx = ex; ex = t;
				t = sy; sy = ey; ey = t;
			end
			if (ax > bx) begin
				t = ax; ax = bx; bx = t;
				t = ay; ay = by; by = t;
			end
			dx = ex - sx;
			dy = ey - sy;
			dsq = dx * dx + dy * dy;
			if (dsq == 0) return 0;
			ts = (ax - sx) * dx + (ay - sy) * dy;
			te = (bx - sx) * dx + (by - sy) * dy;
			if (te < 0) begin
				pass_dist = root_floor((bx - sx) * (bx - sx) + (by - sy) * (by - sy));
			end else if (ts > dsq) begin
				pass_dist = root_floor((ax - ex) * (ax - ex) + (ay - ey) * (ay - ey));
			end else begin
				if (ts < 0) c = (by - sy) * dx - (bx - sx) * dy;
				else c = (ay - sy) * dx - (ax - sx) * dy;
				ac = (c < 0) ? longint'(-c) : c;
				len = root_floor(longint'(dsq) << 16);
				pass_dist = (len != 0) ? (ac << 8) / len : spd_pkg::DIST_MAX;
			end
			return 1;
		endfunction

		function void note_pair(spd_pkg::pair_t p);
			longint ax0, ay0, ax1, ay1, bx0, by0, bx1, by1;
			int o1, o2, o3, o4;
			longint unsigned best, d;
			spd_pkg::dist_t r;
			ax0 = p.a_start_x; ay0 = p.a_start_y; ax1 = p.a_end_x; ay1 = p.a_end_y;
			bx0 = p.b_start_x; by0 = p.b_start_y; bx1 = p.b_end_x; by1 = p.b_end_y;
			o1 = turn(ax0, ay0, ax1, ay1, bx0, by0);
			o2 = turn(ax0, ay0, ax1, ay1, bx1, by1);
			o3 = turn(bx0, by0, bx1, by1, ax0, ay0);
			o4 = turn(bx0, by0, bx1, by1, ax1, ay1);
			r = '0;
			if ((o1 != o2 && o3 != o4) ||
				(o1 == 0 && within_box(ax0, ay0, bx0, by0, ax1, ay1)) ||
				(o2 == 0 && within_box(ax0, ay0, bx1, by1, ax1, ay1)) ||
				(o3 == 0 && within_box(bx0, by0, ax0, ay0, bx1, by1)) ||
				(o4 == 0 && within_box(bx0, by0, ax1, ay1, bx1, by1))) begin
				r.intersects = 1'b1;
			end else begin
				best = spd_pkg::DIST_MAX;
				if (run_pass(bx0, by0, bx1, by1, ax0, ay0, ax1, ay1, d)) begin
					if (d < best) best = d;
				end else r.degenerate = 1'b1;
				if (run_pass(ax0, ay0, ax1, ay1, bx0, by0, bx1, by1, d)) begin
					if (d < best) best = d;
				end else r.degenerate = 1'b1;
				r.seg_distance = (best > spd_pkg::DIST_MAX) ? spd_pkg::DIST_MAX
					: best[spd_pkg::DIST_W-1:0];
			end
			pending.push_back(r);
		endfunction

		function void check_result(spd_pkg::dist_t got);
			spd_pkg::dist_t want;
			if (pending.size() == 0) begin
				$error("unexpected result word %h", got);
				errors++;
				return;
			end
			want = pending.pop_front();
			if (got.seg_distance !== want.seg_distance) begin
				$error("seg_distance: expected %0d, actual %0d", want.seg_distance,
					got.seg_distance);
				errors++;
			end
			if (got.intersects !== want.intersects) begin
				$error("intersects: expected %0b, actual %0b", want.intersects, got.intersects);
				errors++;
			end
			if (got.degenerate !== want.degenerate) begin
				$error("degenerate: expected %0b, actual %0b", want.degenerate, got.degenerate);
				errors++;
			end
		endfunction
	endclass

	logic                        clk;
	logic                        arst_n;
	logic                        cfg_we;
	logic [spd_pkg::TOL_W-1:0]   cfg_wdata;
	logic                        pair_valid;
	logic                        pair_ready;
	spd_pkg::pair_t              pair;
	logic                        dist_valid;
	logic                        dist_ready;
	spd_pkg::dist_t              result;

	dist_scoreboard board;
	int               send_idle_pct;
	int               recv_stall_pct;

	segment_pair_distance_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.pair_valid(pair_valid),
		.pair_ready(pair_ready),
		.pair      (pair),
		.dist_valid(dist_valid),
		.dist_ready(dist_ready),
		.result    (result)
	);

	always begin
		clk = 1'b1;
		#1;
		clk = 1'b0;
		#1;
	end

	// Every accepted pair gets its prediction and every accepted result word
	// is checked at the same rising edge where the handshake completes.
	always @(posedge clk) begin
		if (arst_n && pair_valid && pair_ready) board.note_pair(pair);
		if (arst_n && dist_valid && dist_ready) board.check_result(result);
	end

	// The receiver stalls at random; the draw is made at each falling edge.
	always @(negedge clk) begin
		if (!arst_n) dist_ready <= 1'b0;
		else dist_ready <= ($urandom_range(99) >= recv_stall_pct);
	end

	// Drives one pair word, with optional random idle cycles in front, and
	// holds it until the unit takes it. Valid stays high on return so that
	// the next word can follow directly; callers that pause drop it.
	task automatic send_pair(spd_pkg::pair_t p);
		while ($urandom_range(99) < send_idle_pct) begin
			pair_valid <= 1'b0;
			@(negedge clk);
		end
		pair_valid <= 1'b1;
		pair <= p;
		@(posedge clk);
		while (!pair_ready) @(posedge clk);
		@(negedge clk);
	endtask

	// Waits until every predicted word is back, then lets the pipeline drain.
	task automatic drain();
		pair_valid <= 1'b0;
		while (board.pending.size() != 0) @(negedge clk);
		repeat (LATENCY + 8) @(negedge clk);
	endtask

	task automatic write_tolerance(logic [spd_pkg::TOL_W-1:0] v);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(negedge clk);
		cfg_we <= 1'b0;
		board.tolerance = v;
	endtask

	function automatic logic [spd_pkg::COORD_W-1:0] rand_coord(int mode,
		logic [spd_pkg::COORD_W-1:0] base);
		unique case (mode)
			0: return spd_pkg::COORD_W'($urandom);
			1: return base + spd_pkg::COORD_W'($urandom_range(2047))
				- spd_pkg::COORD_W'(1024);
			default: return ($urandom_range(1)) ? {spd_pkg::COORD_W{1'b1}} : '0;
		endcase
	endfunction

	// Random pairs: mostly a shared neighborhood so that touching, colinear
	// and near cases occur often, with some full range and some extremes.
	function automatic spd_pkg::pair_t rand_pair();
		spd_pkg::pair_t p;
		int mode;
		logic [spd_pkg::COORD_W-1:0] cx, cy;
		int k;
		cx = spd_pkg::COORD_W'($urandom);
		cy = spd_pkg::COORD_W'($urandom);
		k = $urandom_range(99);
		mode = (k < 25) ? 0 : ((k < 92) ? 1 : 2);
		p.a_start_x = rand_coord(mode, cx);
		p.a_start_y = rand_coord(mode, cy);
		p.a_end_x = rand_coord(mode, cx);
		p.a_end_y = rand_coord(mode, cy);
		p.b_start_x = rand_coord(mode, cx);
		p.b_start_y = rand_coord(mode, cy);
		p.b_end_x = rand_coord(mode, cx);
		p.b_end_y = rand_coord(mode, cy);
		k = $urandom_range(9);
		if (k == 0) begin
			p.a_end_x = p.a_start_x;
			p.a_end_y = p.a_start_y;
		end else if (k == 1) begin
			p.b_end_x = p.b_start_x;
			p.b_end_y = p.b_start_y;
		end else if (k == 2) begin
			// B starts on the line of A, beyond the end of A.
			p.b_start_x = p.a_end_x + (p.a_end_x - p.a_start_x);
			p.b_start_y = p.a_end_y + (p.a_end_y - p.a_start_y);
		end
		return p;
	endfunction

	function automatic spd_pkg::pair_t make_pair(int ax0, int ay0, int ax1, int ay1, int bx0,
		int by0, int bx1, int by1);
		spd_pkg::pair_t p;
		p = '{spd_pkg::COORD_W'(ax0), spd_pkg::COORD_W'(ay0), spd_pkg::COORD_W'(ax1),
			spd_pkg::COORD_W'(ay1), spd_pkg::COORD_W'(bx0), spd_pkg::COORD_W'(by0),
			spd_pkg::COORD_W'(bx1), spd_pkg::COORD_W'(by1)};
		return p;
	endfunction

	initial begin
		#4000000;
		$display("TB_ERROR");
		$finish;
	end

	initial begin
		int phase;
		int m;
		int unsigned top;
		board = new();
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		pair_valid = 1'b0;
		pair = '0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		top = (1 << spd_pkg::COORD_W) - 1;
		repeat (5) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Directed pairs at the reset tolerance: crossing, touching at an end,
		// colinear overlap and gap, parallel, both degenerate, one degenerate,
		// far corners for saturation and endpoint and perpendicular cases.
		send_pair(make_pair(0, 0, 1000, 1000, 0, 1000, 1000, 0));
		send_pair(make_pair(0, 0, 500, 500, 500, 500, 900, 100));
		send_pair(make_pair(0, 0, 1000, 0, 500, 0, 2000, 0));
		send_pair(make_pair(0, 0, 1000, 0, 1500, 0, 2000, 0));
		send_pair(make_pair(0, 0, 1000, 0, 0, 300, 1000, 300));
		send_pair(make_pair(5, 5, 5, 5, 700, 900, 700, 900));
		send_pair(make_pair(5, 5, 5, 5, 0, 100, 1000, 100));
		send_pair(make_pair(0, 0, 0, 0, top, top, top, top));
		send_pair(make_pair(0, 0, 0, 10, top, top, top, top - 10));
		send_pair(make_pair(top, 0, top, 0, 0, top, 0, top));
		send_pair(make_pair(0, 0, 100, 0, 300, 50, 400, 900));
		send_pair(make_pair(1000, 0, 2000, 0, 0, 100, 500, 700));
		send_pair(make_pair(0, 0, 1000, 10, 200, 400, 800, 400));
		send_pair(make_pair(2000, 0, 1000, 500, 0, 900, 3000, 900));
		send_pair(make_pair(top, top, 0, 0, top, 0, top, 100));
		send_pair(make_pair(0, top, top, 0, 0, 0, 10, 10));
		send_pair(make_pair(0, 0, 1000, 1, 2000, 2, 3000, 3));

		// Phases: tolerance and idling mix change between them, always with
		// the unit idle.
		for (phase = 0; phase < 8; phase++) begin
			drain();
			unique case (phase)
				0: write_tolerance(16'hFFFF);
				1: write_tolerance('0);
				2: write_tolerance(16'd300);
				3: write_tolerance(16'h5555);
				4: write_tolerance(16'hAAAA);
				5: write_tolerance(spd_pkg::TOL_RESET);
				6: write_tolerance(spd_pkg::TOL_W'($urandom));
				default: write_tolerance(16'd40000);
			endcase
			send_idle_pct = (phase % 4 == 1 || phase % 4 == 3) ? 70 : 0;
			recv_stall_pct = (phase % 4 == 2) ? 70 : ((phase % 4 == 3) ? 19 : 0);
			if (phase % 4 == 3) send_idle_pct = 19;
			for (m = 0; m < 185; m++) begin
				send_pair(rand_pair());
				// Hold the sender until the unit is empty, once per phase.
				if (m == 90) begin
					pair_valid <= 1'b0;
					while (board.pending.size() != 0) @(negedge clk);
				end
			end
		end

		drain();
		if (board.errors == 0 && board.pending.size() == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule

[filelist.f]
hdl/spd_pkg.sv
hdl/spd_front.sv
hdl/spd_isqrt.sv
hdl/spd_div.sv
hdl/segment_pair_distance_unit.sv
test/tb_segment_pair_distance_unit.sv
